// ===== sv/adc_window_avg_min_max_assert.svh =====
// Assertion macros for the ADC window mean/min/max block.
`ifndef ADC_WINDOW_AVG_MIN_MAX_ASSERT_SVH
`define ADC_WINDOW_AVG_MIN_MAX_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define AWMM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("awmm: same-cycle check failed");
// Next-cycle implication, disabled while reset is active.
`define AWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("awmm: next-cycle check failed");
`else
`define AWMM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/awmm_pkg.sv =====
// Shared types and constants for the ADC window mean/min/max block.
`timescale 1ns / 1ps
package awmm_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WRITE,
    ST_SCAN,
    ST_LOAD,
    ST_DONE
  } awmm_state_e;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic clear;     // start a new scan
    logic acc;       // ring read data is valid, fold it in
    logic div_load;  // multiply the sum by the window reciprocal
  } awmm_dp_ctrl_t;

endpackage

// ===== sv/awmm_if.sv =====
// Valid/ready channel interfaces for samples and window results.
`timescale 1ns / 1ps
interface awmm_sample_if;
  import awmm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface awmm_result_if;
  import awmm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t window_mean;
  sample_t window_min;
  sample_t window_max;

  modport source (output valid, output window_mean, output window_min, output window_max,
                  input ready);
  modport sink (input valid, input window_mean, input window_min, input window_max,
                output ready);
endinterface

// ===== sv/awmm_ring.sv =====
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps
module awmm_ring #(
  parameter int unsigned WINDOW = 16,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  awmm_pkg::sample_t        wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output awmm_pkg::sample_t        rdata_o
);
  import awmm_pkg::*;

  sample_t mem [WINDOW];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/awmm_dp.sv =====
// Shared datapath: running sum/min/max over the scan, then mean by shift or reciprocal.
`timescale 1ns / 1ps
module awmm_dp #(
  parameter int unsigned WINDOW = 16,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic                    clk_i,
  input  awmm_pkg::awmm_dp_ctrl_t ctrl_i,
  input  awmm_pkg::sample_t       rdata_i,
  output awmm_pkg::sample_t       mean_o,
  output awmm_pkg::sample_t       min_o,
  output awmm_pkg::sample_t       max_o
);
  import awmm_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + AW;
  localparam bit IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

  logic [SUM_W-1:0] sum_q, sum_d;
  sample_t          min_q, min_d;
  sample_t          max_q, max_d;

  always_comb begin
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
      min_d = SAMPLE_MAX;
      max_d = '0;
    end else if (ctrl_i.acc) begin
      sum_d = sum_q + SUM_W'(rdata_i);
      if (rdata_i < min_q) min_d = rdata_i;
      if (rdata_i > max_q) max_d = rdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    min_q <= min_d;
    max_q <= max_d;
  end

  assign min_o = min_q;
  assign max_o = max_q;

  if (IS_POW2) begin : g_shift
    assign mean_o = sum_q[AW +: SAMPLE_W];
  end else begin : g_div
    // sum < 2^SUM_W; with m = floor(2^(SUM_W+AW)/WINDOW)+1 the product
    // shifted right by SUM_W+AW is the exact truncated quotient.
    localparam int unsigned SHIFT   = SUM_W + AW;
    localparam int unsigned RECIP_W = SUM_W + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) / 64'(WINDOW)) + 64'd1;

    logic [PROD_W-1:0] prod_q;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.div_load) begin
        prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP_W'(RECIP));
      end
    end

    assign mean_o = prod_q[SHIFT +: SAMPLE_W];
  end

endmodule

// ===== sv/awmm_seq.sv =====
// Sequencer: ring fill, sample write, window scan, mean, result hand-off.
`timescale 1ns / 1ps
module awmm_seq #(
  parameter int unsigned WINDOW = 16,
  localparam int unsigned AW = $clog2(WINDOW)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    ring_we_o,
  output logic [AW-1:0]           ring_waddr_o,
  output logic                    ring_re_o,
  output logic [AW-1:0]           ring_raddr_o,
  output awmm_pkg::awmm_dp_ctrl_t dp_ctrl_o
);
  import awmm_pkg::*;

  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned CNT_W = (CW > 4) ? CW : 4;
  localparam bit IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

  awmm_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic             primed_q, primed_d;
  logic             rd_pend_q, rd_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      slot_q    <= '0;
      primed_q  <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      primed_q  <= primed_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    primed_d     = primed_q;
    rd_pend_d    = 1'b0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    ring_we_o    = 1'b0;
    ring_waddr_o = slot_q;
    ring_re_o    = 1'b0;
    ring_raddr_o = cnt_q[AW-1:0];
    dp_ctrl_o    = '0;
    dp_ctrl_o.acc = rd_pend_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cnt_d      = '0;
        if (in_valid_i) begin
          state_d = primed_q ? ST_WRITE : ST_FILL;
        end
      end
      ST_FILL: begin
        // first sample after reset goes to every slot
        ring_we_o    = 1'b1;
        ring_waddr_o = cnt_q[AW-1:0];
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WINDOW - 1)) begin
          primed_d = 1'b1;
          cnt_d    = '0;
          state_d  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ring_we_o       = 1'b1;
        slot_d          = (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
        dp_ctrl_o.clear = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(WINDOW)) begin
          // last read data is folded in on this edge
          cnt_d   = '0;
          state_d = IS_POW2 ? ST_DONE : ST_LOAD;
        end else begin
          ring_re_o = 1'b1;
          rd_pend_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ST_LOAD: begin
        dp_ctrl_o.div_load = 1'b1;
        cnt_d              = '0;
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/adc_window_avg_min_max.sv =====
// Top level of the ADC sliding-window mean/min/max block.
`timescale 1ns / 1ps
// Sliding-window statistics over 12-bit ADC samples. The block keeps the last
// WINDOW samples in a single-port-read ring memory and returns one
// result transaction per sample transaction: truncated mean, minimum and
// maximum of the samples now held. The first sample after reset fills the
// whole ring, so its result equals the sample. One sample is handled at a
// time: sample ready is high only while the block is idle. An accepted sample
// is written to the ring, then the ring is scanned, one entry read per cycle
// through the memory's read port, and each entry is folded into the running
// sum, minimum and maximum. When WINDOW is a power of two the mean is then a
// shift of the sum; otherwise a load step multiplies the sum by the window
// reciprocal before the result is valid. The first sample after reset first
// fills the whole ring before its write. A new sample is taken the cycle after
// the result is taken.
module adc_window_avg_min_max #(
  parameter int unsigned WINDOW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  awmm_sample_if.sink   sample_i,
  awmm_result_if.source result_o
);
  import awmm_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);

  sample_t       sample_q;
  logic          in_ready;
  logic          out_valid;
  logic          ring_we;
  logic [AW-1:0] ring_waddr;
  logic          ring_re;
  logic [AW-1:0] ring_raddr;
  sample_t       ring_rdata;
  awmm_dp_ctrl_t dp_ctrl;
  sample_t       mean;
  sample_t       win_min;
  sample_t       win_max;

  // Input sample is held for the fill and the ring write.
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && in_ready) begin
      sample_q <= sample_i.sample;
    end
  end

  awmm_seq #(
    .WINDOW (WINDOW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (sample_i.valid),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .out_ready_i  (result_o.ready),
    .ring_we_o    (ring_we),
    .ring_waddr_o (ring_waddr),
    .ring_re_o    (ring_re),
    .ring_raddr_o (ring_raddr),
    .dp_ctrl_o    (dp_ctrl)
  );

  awmm_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (sample_q),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  awmm_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i   (clk_i),
    .ctrl_i  (dp_ctrl),
    .rdata_i (ring_rdata),
    .mean_o  (mean),
    .min_o   (win_min),
    .max_o   (win_max)
  );

  assign sample_i.ready       = in_ready;
  assign result_o.valid       = out_valid;
  assign result_o.window_mean = mean;
  assign result_o.window_min  = win_min;
  assign result_o.window_max  = win_max;

`include "adc_window_avg_min_max_assert.svh"

  // never take a sample while a result is pending
  `AWMM_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  // taking the result frees the block at once
  `AWMM_ASSERT_NEXT(a_ready_after_result, clk_i, rst_ni, out_valid && result_o.ready, in_ready)
  // statistics are consistent with each other
  `AWMM_ASSERT_NOW(a_min_le_max, clk_i, rst_ni, out_valid, win_min <= win_max)
  `AWMM_ASSERT_NOW(a_mean_in_range, clk_i, rst_ni, out_valid, mean >= win_min && mean <= win_max)

endmodule
